// ===== hdl/tbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcf_pkg: shared types and constants for the triple-bank frame store
// Holds the command codes, the sequencer states, the field widths and the
// packed words that travel on the request and response channels.
// ----------------------------------------------------------------------------
package tbcf_pkg;

   localparam int CNT_W          = 6;
   localparam int IDX_W          = 5;
   localparam int POS_W          = 8;
   localparam int STORE_W        = 7;
   localparam int BSEL_W         = 2;
   localparam int DIST_W         = 8;
   localparam int MAX_SERVOS_DEF = 32;

   localparam logic [CNT_W-1:0]  COUNT_RESET = 6'd32;
   localparam logic [BSEL_W-1:0] BANK_CUR    = 2'd0;
   localparam logic [BSEL_W-1:0] BANK_LAST   = 2'd1;
   localparam logic [BSEL_W-1:0] BANK_NEXT   = 2'd2;

   typedef enum logic [2:0] {
      CMD_WRITE     = 3'd0,
      CMD_READ      = 3'd1,
      CMD_WRITE_ALL = 3'd2,
      CMD_COPY_NEXT = 3'd3,
      CMD_COPY_LAST = 3'd4,
      CMD_SWAP      = 3'd5,
      CMD_FADE      = 3'd6,
      CMD_SEND      = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SINGLE,
      ST_LOOP_RD,
      ST_LOOP_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type               command;
      logic [IDX_W-1:0]      servo_index;
      logic [POS_W-1:0]      position_value;
      logic [BSEL_W-1:0]     bank_select;
      logic [DIST_W-1:0]     fade_distance;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]      index_echo;
      logic [STORE_W-1:0]    read_value;
      logic [STORE_W-1:0]    pin_word;
   } rsp_word_type;

endpackage

// ===== hdl/tbcf_store_ram.sv =====
// ----------------------------------------------------------------------------
// tbcf_store_ram: frame store memory
// One write port and two registered read ports over all three banks.
// ----------------------------------------------------------------------------
module tbcf_store_ram
   import tbcf_pkg::*;
#(
   parameter int DEPTH = 3 * MAX_SERVOS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [STORE_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output logic [STORE_W-1:0] rd_data_a,
   output logic [STORE_W-1:0] rd_data_b
);

   logic [STORE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Addresses past the end only occur for reads whose data is discarded.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== hdl/tbcf_blend.sv =====
// ----------------------------------------------------------------------------
// tbcf_blend: shared entry arithmetic
// Forms the value written back for one entry of a bulk command: fill value,
// copied entry, or the linear crossfade between the last and next entries.
// ----------------------------------------------------------------------------
module tbcf_blend
   import tbcf_pkg::*;
(
   input  cmd_type            cmd,
   input  logic [STORE_W-1:0] last_data,
   input  logic [STORE_W-1:0] next_data,
   input  logic [DIST_W-1:0]  distance,
   input  logic [STORE_W-1:0] fill_data,
   output logic [STORE_W-1:0] result
);

   logic signed [STORE_W+1:0]            delta;
   logic signed [STORE_W+DIST_W+2:0]     product;
   logic        [STORE_W-1:0]            step;

   // Only product bits 14:8 are used; the store keeps seven bits.
   always_comb begin
      delta   = $signed({2'b00, next_data} - {2'b00, last_data});
      product = delta * $signed({1'b0, distance});
      step    = product[DIST_W+STORE_W-1:DIST_W];
   end

   always_comb begin
      unique case (cmd)
         CMD_WRITE_ALL: result = fill_data;
         CMD_COPY_NEXT: result = next_data;
         CMD_COPY_LAST: result = last_data;
         CMD_FADE:      result = last_data + step;
         default:       result = '0;
      endcase
   end

endmodule

// ===== hdl/triple_bank_crossfade_frame_store.sv =====
// ----------------------------------------------------------------------------
// triple_bank_crossfade_frame_store: three-bank servo position store
// Keeps current, last and next banks of 7-bit servo positions and runs
// per-entry commands and whole-bank copies and crossfades through one
// shared arithmetic unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Direction  Word
//  request   req_valid req_stall req_data   in         req_word_type
//  response  rsp_valid rsp_stall rsp_data   out        rsp_word_type
//  config    csr_write csr_wdata            in         servo count, 6 bits
//
// Single-entry commands (write, read, swap, send) pass from acceptance
// through the single-step and finish states to a registered response word.
// Write all, both copies and the fade then walk the active entries, each
// with a read step on the two memory read ports and a write step through
// the blend unit, before the finish state.
// After reset a clearing pass writes zero to all 3*MAX_SERVOS entries, one
// per cycle, and no request word is taken meanwhile.
// A new request word is taken only in the idle state, and only when the
// response register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module triple_bank_crossfade_frame_store
   import tbcf_pkg::*;
#(
   parameter int MAX_SERVOS = MAX_SERVOS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_data,
   input  logic              csr_write,
   input  logic [CNT_W-1:0]  csr_wdata
);

   localparam int DEPTH = 3 * MAX_SERVOS;
   localparam int AW    = $clog2(DEPTH);

   // Sequencer and item registers.
   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [POS_W-1:0]    val_ff, val_in;
   logic [BSEL_W-1:0]   bsel_ff, bsel_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [AW-1:0]       clr_ff, clr_in;

   // Architectural state.
   logic [BSEL_W-1:0]   last_ff, last_in;
   logic [BSEL_W-1:0]   next_ff, next_in;
   logic [STORE_W-1:0]  pin_ff, pin_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;

   // Memory port and derived values.
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [STORE_W-1:0]  mem_wdata;
   logic [AW-1:0]       mem_raddr_a;
   logic [AW-1:0]       mem_raddr_b;
   logic [STORE_W-1:0]  mem_rdata_a;
   logic [STORE_W-1:0]  mem_rdata_b;
   logic [STORE_W-1:0]  blend_data;

   logic                accept;
   logic [CNT_W-1:0]    cnt;
   logic                cnt_zero;
   logic                idx_in_range;
   logic                last_iter;
   logic                is_loop;
   logic [AW-1:0]       cnt_a;
   logic [AW-1:0]       cnt2_a;
   logic [AW-1:0]       i_a;
   logic [AW-1:0]       idx_a;
   logic [BSEL_W-1:0]   sel_bank;
   logic [AW-1:0]       sel_base;
   logic [AW-1:0]       last_base;
   logic [AW-1:0]       next_base;

   // A count above MAX_SERVOS is taken as MAX_SERVOS.
   always_comb begin
      cnt = ({2'b00, count_ff} > 8'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS) : count_ff;
      cnt_zero     = (cnt == '0);
      idx_in_range = ({1'b0, idx_ff} < cnt);
      last_iter    = (i_ff == CNT_W'(cnt - 1'b1));
      is_loop      = cmd_ff inside {CMD_WRITE_ALL, CMD_COPY_NEXT, CMD_COPY_LAST, CMD_FADE};
   end

   // Entry i of bank b sits at b*count + i. The bank pointers only ever
   // hold 1 or 2, so with bank 0 the product selects 0, count or 2*count.
   always_comb begin
      cnt_a  = AW'(cnt);
      cnt2_a = AW'({cnt, 1'b0});
      i_a    = AW'(i_ff);
      idx_a  = AW'(idx_ff);
      if (bsel_ff == BANK_CUR) begin
         sel_bank = BANK_CUR;
      end else if (bsel_ff == BANK_NEXT) begin
         sel_bank = next_ff;
      end else begin
         sel_bank = last_ff;
      end
      sel_base  = sel_bank[1] ? cnt2_a : (sel_bank[0] ? cnt_a : '0);
      last_base = last_ff[1]  ? cnt2_a : (last_ff[0]  ? cnt_a : '0);
      next_base = next_ff[1]  ? cnt2_a : (next_ff[0]  ? cnt_a : '0);
   end

   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            state_in = (is_loop && !cnt_zero) ? ST_LOOP_RD : ST_FINISH;
         end
         ST_LOOP_RD: begin
            state_in = ST_LOOP_WR;
         end
         ST_LOOP_WR: begin
            state_in = last_iter ? ST_FINISH : ST_LOOP_RD;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port control.
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr_a = '0;
      mem_raddr_b = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ST_SINGLE: begin
            // Send always reads the first entry of the store.
            mem_raddr_a = (cmd_ff == CMD_SEND) ? '0 : sel_base + idx_a;
            if (cmd_ff == CMD_WRITE && !cnt_zero && idx_in_range) begin
               mem_we    = 1'b1;
               mem_waddr = sel_base + idx_a;
               mem_wdata = val_ff[POS_W-1:1];
            end
         end
         ST_LOOP_RD: begin
            mem_raddr_a = last_base + i_a;
            mem_raddr_b = next_base + i_a;
         end
         ST_LOOP_WR: begin
            mem_we    = 1'b1;
            mem_wdata = blend_data;
            unique case (cmd_ff)
               CMD_WRITE_ALL: mem_waddr = sel_base + i_a;
               CMD_COPY_NEXT: mem_waddr = last_base + i_a;
               default:       mem_waddr = i_a;
            endcase
         end
         default: begin
         end
      endcase
   end

   // Register next values.
   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      bsel_in      = bsel_ff;
      dist_in      = dist_ff;
      i_in         = i_ff;
      clr_in       = clr_ff;
      last_in      = last_ff;
      next_in      = next_ff;
      pin_in       = pin_ff;
      count_in     = csr_write ? csr_wdata : count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         cmd_in  = req_data.command;
         idx_in  = req_data.servo_index;
         val_in  = req_data.position_value;
         bsel_in = req_data.bank_select;
         dist_in = req_data.fade_distance;
      end

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end

      if (state_ff == ST_SINGLE) begin
         i_in = '0;
         if (cmd_ff == CMD_SWAP) begin
            last_in = next_ff;
            next_in = last_ff;
         end
      end

      if (state_ff == ST_LOOP_WR) begin
         i_in = i_ff + 1'b1;
      end

      // The read issued in the single-step state has landed by now.
      if (state_ff == ST_FINISH) begin
         if (cmd_ff == CMD_SEND) begin
            pin_in = mem_rdata_a;
         end
         rsp_valid_in           = 1'b1;
         rsp_data_in.index_echo = (cmd_ff == CMD_WRITE && !cnt_zero) ? idx_ff : '0;
         rsp_data_in.read_value = (cmd_ff == CMD_READ && idx_in_range) ? mem_rdata_a : '0;
         rsp_data_in.pin_word   = (cmd_ff == CMD_SEND) ? mem_rdata_a : pin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         clr_ff       <= '0;
         last_ff      <= BANK_LAST;
         next_ff      <= BANK_NEXT;
         pin_ff       <= '0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         next_ff      <= next_in;
         pin_ff       <= pin_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      bsel_ff     <= bsel_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tbcf_store_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   tbcf_blend u_blend (
      .cmd       (cmd_ff),
      .last_data (mem_rdata_a),
      .next_data (mem_rdata_b),
      .distance  (dist_ff),
      .fill_data (val_ff[POS_W-1:1]),
      .result    (blend_data)
   );

`ifndef SYNTHESIS
   // The two swappable pointers always name the two non-current banks.
   a_banks_distinct: assert property (@(posedge clock) disable iff (reset)
      (last_ff != next_ff) && (last_ff != BANK_CUR) && (next_ff != BANK_CUR))
      else $error("last and next bank pointers collide");

   // The response register is free whenever a result is about to be loaded.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !rsp_valid_ff)
      else $error("response register overwritten");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> rsp_valid_ff)
      else $error("finished command produced no response");

   // The entry walk stays inside the active count.
   a_loop_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP_WR) |-> (i_ff < cnt))
      else $error("entry walk past active count");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("store written while idle");
`endif

endmodule

// ===== verif/crossfade_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfade_store_checker: response predictor and scoreboard
// Watches the request, response and configuration ports of the triple-bank
// frame store. It keeps its own copy of the banks and pointers, works out the
// response word for every accepted request word, and compares each accepted
// response word with the oldest one still due.
// ----------------------------------------------------------------------------
module crossfade_store_checker
   import tbcf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_word_type      req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_word_type      rsp_data,
   input  logic              csr_write,
   input  logic [CNT_W-1:0]  csr_wdata,
   output int                error_count,
   output int                words_checked,
   output int                words_due
);

   localparam int DEPTH = 3 * MAX_SERVOS_DEF;
   // Bank select three falls back to the last bank.
   localparam logic [BSEL_W-1:0] BANK_ALIAS = 2'd3;

   logic [STORE_W-1:0] bank_mem [DEPTH];
   logic [1:0]         last_ptr;
   logic [1:0]         next_ptr;
   logic [STORE_W-1:0] pin_latch;
   logic [CNT_W-1:0]   count_reg;
   rsp_word_type       due_q [$];
   int                 errs;
   int                 checked;

   function automatic int unsigned live_count();
      return (count_reg > MAX_SERVOS_DEF) ? MAX_SERVOS_DEF : int'(count_reg);
   endfunction

   function automatic int unsigned bank_base(logic [BSEL_W-1:0] sel);
      if (sel == BANK_LAST || sel == BANK_ALIAS)
         return last_ptr;
      if (sel == BANK_NEXT)
         return next_ptr;
      return BANK_CUR;
   endfunction

   // Applies one command to the model state and returns its response word.
   function automatic rsp_word_type execute(req_word_type w);
      int unsigned        cnt;
      int unsigned        i;
      logic [STORE_W-1:0] a;
      logic [STORE_W-1:0] b;
      logic [31:0]        diff;
      logic [31:0]        prod;
      logic [7:0]         mix;
      rsp_word_type       r;
      cnt = live_count();
      r = '0;
      case (w.command)
         CMD_WRITE: begin
            if (cnt != 0) begin
               r.index_echo = w.servo_index;
               if (w.servo_index < cnt)
                  bank_mem[bank_base(w.bank_select) * cnt + w.servo_index] =
                     w.position_value[POS_W-1:1];
            end
         end
         CMD_READ: begin
            if (w.servo_index < cnt)
               r.read_value = bank_mem[bank_base(w.bank_select) * cnt + w.servo_index];
         end
         CMD_WRITE_ALL: begin
            for (i = 0; i < cnt; i++)
               bank_mem[bank_base(w.bank_select) * cnt + i] = w.position_value[POS_W-1:1];
         end
         CMD_COPY_NEXT: begin
            for (i = 0; i < cnt; i++)
               bank_mem[last_ptr * cnt + i] = bank_mem[next_ptr * cnt + i];
         end
         CMD_COPY_LAST: begin
            for (i = 0; i < cnt; i++)
               bank_mem[i] = bank_mem[last_ptr * cnt + i];
         end
         CMD_SWAP: begin
            {last_ptr, next_ptr} = {next_ptr, last_ptr};
         end
         CMD_FADE: begin
            // The difference wraps as a 32-bit quantity, so a fade toward a
            // smaller value lands wherever the modulo-256 sum puts it.
            for (i = 0; i < cnt; i++) begin
               a = bank_mem[last_ptr * cnt + i];
               b = bank_mem[next_ptr * cnt + i];
               diff = {25'd0, b} - {25'd0, a};
               prod = diff * {24'd0, w.fade_distance};
               mix = {1'b0, a} + prod[15:8];
               bank_mem[i] = mix[STORE_W-1:0];
            end
         end
         CMD_SEND: begin
            pin_latch = bank_mem[0];
         end
         default: ;
      endcase
      r.pin_word = pin_latch;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++)
            bank_mem[k] = '0;
         last_ptr = BANK_LAST;
         next_ptr = BANK_NEXT;
         pin_latch = '0;
         count_reg = COUNT_RESET;
         due_q.delete();
         errs = 0;
         checked = 0;
      end else begin
         if (csr_write)
            count_reg = csr_wdata;
         // Responses are matched before this edge's request is added, so a
         // word accepted now can never be taken for one leaving now.
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               errs++;
               $error("response word with nothing due: %p", rsp_data);
            end else begin
               want = due_q.pop_front();
               checked++;
               if (rsp_data.index_echo !== want.index_echo) begin
                  errs++;
                  $error("index_echo: expected %0d, got %0d",
                         want.index_echo, rsp_data.index_echo);
               end
               if (rsp_data.read_value !== want.read_value) begin
                  errs++;
                  $error("read_value: expected %0d, got %0d",
                         want.read_value, rsp_data.read_value);
               end
               if (rsp_data.pin_word !== want.pin_word) begin
                  errs++;
                  $error("pin_word: expected %0d, got %0d",
                         want.pin_word, rsp_data.pin_word);
               end
            end
         end
         if (req_valid && !req_stall)
            due_q.push_back(execute(req_data));
      end
      error_count <= errs;
      words_checked <= checked;
      words_due <= due_q.size();
   end

endmodule

// ===== verif/triple_bank_crossfade_frame_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_bank_crossfade_frame_store_tb: top level of the frame store bench
// Drives a directed opening and then random command streams through the
// request channel under a series of servo counts, with random idling on both
// channels. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module triple_bank_crossfade_frame_store_tb;
   import tbcf_pkg::*;

   // Longest correct quiet stretch is the clearing pass or a bank walk
   // followed by a long receiver stall; this limit is far above either.
   localparam int WATCHDOG_LIMIT = 5000;
   // After the last response, give the block more than one full bank walk
   // to show any stray word.
   localparam int DRAIN_CYCLES   = 80;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 85;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   req_word_type     req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   rsp_word_type     rsp_data;
   logic             csr_write  = 1'b0;
   logic [CNT_W-1:0] csr_wdata  = '0;

   int error_count;
   int words_checked;
   int words_due;

   // Percentages of cycles in which the sender holds back a word and the
   // receiver stalls the response channel.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int words_sent   = 0;
   int walk_words   = 0;
   int quiet_cycles = 0;
   int live         = MAX_SERVOS_DEF;

   // Servo counts for the random phases: over-range, one, odd, zero, full,
   // a middle value, a second over-range value, and one drawn at random.
   int phase_count [PHASES] = '{63, 1, 13, 0, 32, 24, 40, 0};

   always #4 clock = ~clock;

   triple_bank_crossfade_frame_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   crossfade_store_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .words_checked (words_checked),
      .words_due     (words_due)
   );

   // The receiver decides afresh every cycle whether to stall.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Any accepted word or register write counts as progress. A long run of
   // cycles without progress means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type make_word(cmd_type cmd, int idx, int pos, int sel,
                                              int fade_amt);
      req_word_type w;
      w.command = cmd;
      w.servo_index = idx[IDX_W-1:0];
      w.position_value = pos[POS_W-1:0];
      w.bank_select = sel[BSEL_W-1:0];
      w.fade_distance = fade_amt[DIST_W-1:0];
      return w;
   endfunction

   // Random command mix: mostly single-entry writes and reads with indexes in
   // range, so the banks fill with varied values, plus a steady share of bank
   // walks, swaps and sends that move those values around.
   function automatic req_word_type random_word();
      req_word_type w;
      int           roll;
      int           idx;
      int           fade_amt;
      cmd_type      cmd;
      roll = $urandom_range(99);
      if (roll < 35)
         cmd = CMD_WRITE;
      else if (roll < 63)
         cmd = CMD_READ;
      else if (roll < 70)
         cmd = CMD_WRITE_ALL;
      else if (roll < 76)
         cmd = CMD_COPY_NEXT;
      else if (roll < 81)
         cmd = CMD_COPY_LAST;
      else if (roll < 87)
         cmd = CMD_SWAP;
      else if (roll < 94)
         cmd = CMD_FADE;
      else
         cmd = CMD_SEND;
      // Roughly one index in seven is drawn from the whole field so that
      // writes and reads past the active count turn up.
      if (live > 0 && $urandom_range(6) != 0)
         idx = $urandom_range(live - 1);
      else
         idx = $urandom_range(31);
      roll = $urandom_range(9);
      if (roll == 0)
         fade_amt = 0;
      else if (roll == 1)
         fade_amt = 255;
      else
         fade_amt = $urandom_range(255);
      w = make_word(cmd, idx, $urandom_range(255), $urandom_range(3), fade_amt);
      return w;
   endfunction

   // Offers one word and returns at the edge where it is accepted. The valid
   // stays high into the next call, so back-to-back words need no gap.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (w.command inside {CMD_WRITE_ALL, CMD_COPY_NEXT, CMD_COPY_LAST, CMD_FADE})
         walk_words++;
   endtask

   // Waits until every response due has been taken. The first edge lets the
   // checker count a word accepted at the edge this task was entered on.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   // The count register is only written with the block idle.
   task automatic set_servo_count(int n);
      drain_responses();
      csr_write <= 1'b1;
      csr_wdata <= n[CNT_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      live = (n > MAX_SERVOS_DEF) ? MAX_SERVOS_DEF : n;
   endtask

   initial begin
      // Reset is held at the start; the block then runs its clearing
      // pass and holds off the first word on its own.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 29;
      receiver_stall_pct = 86;

      // Directed opening at the reset count of 32. Entry extremes in every
      // bank, bank select three standing for the last bank, fades at zero,
      // full and half distance, the last one running the difference below
      // zero after the swap.
      send_word(make_word(CMD_WRITE, 0, 255, BANK_CUR, 0));
      send_word(make_word(CMD_WRITE, 31, 1, BANK_LAST, 0));
      send_word(make_word(CMD_WRITE, 31, 254, BANK_NEXT, 0));
      send_word(make_word(CMD_WRITE, 5, 200, 3, 0));
      send_word(make_word(CMD_READ, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_READ, 5, 0, BANK_LAST, 0));
      send_word(make_word(CMD_READ, 31, 0, BANK_NEXT, 0));
      send_word(make_word(CMD_SEND, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_WRITE_ALL, 0, 130, BANK_NEXT, 0));
      send_word(make_word(CMD_WRITE_ALL, 0, 10, BANK_LAST, 0));
      send_word(make_word(CMD_FADE, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_FADE, 0, 0, BANK_CUR, 255));
      send_word(make_word(CMD_SWAP, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_FADE, 0, 0, BANK_CUR, 128));
      send_word(make_word(CMD_COPY_NEXT, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_COPY_LAST, 0, 0, BANK_CUR, 0));
      send_word(make_word(CMD_SEND, 0, 0, BANK_CUR, 0));

      // A short bank of five: indexes past the count are echoed on a write
      // but store nothing, and read back as zero.
      set_servo_count(5);
      send_word(make_word(CMD_WRITE, 7, 77, BANK_LAST, 0));
      send_word(make_word(CMD_READ, 7, 0, BANK_LAST, 0));
      send_word(make_word(CMD_WRITE, 4, 99, BANK_NEXT, 0));
      send_word(make_word(CMD_READ, 4, 0, 3, 0));

      // With a count of zero nothing is stored or walked and the echo is
      // zero, but a send still picks up the first entry of the store.
      set_servo_count(0);
      send_word(make_word(CMD_WRITE, 9, 50, BANK_CUR, 0));
      send_word(make_word(CMD_WRITE_ALL, 0, 255, BANK_CUR, 0));
      send_word(make_word(CMD_FADE, 0, 0, BANK_CUR, 255));
      send_word(make_word(CMD_SEND, 0, 0, BANK_CUR, 0));

      // Random phases. The first three idle the sender lightly and the
      // receiver heavily, the next three the other way round, the last two
      // not at all.
      phase_count[PHASES-1] = $urandom_range(0, 63);
      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            sender_idle_pct = 86;
            receiver_stall_pct = 29;
         end else if (p == 6) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         set_servo_count(phase_count[p]);
         // A count of zero leaves only trivial answers, so that phase is short.
         for (int n = 0; n < ((phase_count[p] == 0) ? 30 : PHASE_WORDS); n++)
            send_word(random_word());
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words, %0d of them whole-bank walks, over %0d",
               words_sent, walk_words, PHASES + 3);
      $display("servo-count settings including zero and over-range; %0d responses checked.",
               words_checked);
      if (error_count == 0 && words_due == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tbcf_pkg.sv
hdl/tbcf_store_ram.sv
hdl/tbcf_blend.sv
hdl/triple_bank_crossfade_frame_store.sv
verif/crossfade_store_checker.sv
verif/triple_bank_crossfade_frame_store_tb.sv
